[rtl/q16_pkg.sv]
package q16_pkg;

  localparam int FracBitsDefault = 16;
  localparam int FloatExpOffset  = 150;

  localparam logic [2:0] OpMul   = 3'd0;
  localparam logic [2:0] OpDiv   = 3'd1;
  localparam logic [2:0] OpFloat = 3'd2;
  localparam logic [2:0] OpAbs   = 3'd3;
  localparam logic [2:0] OpSqrt  = 3'd4;
  localparam logic [2:0] OpCbrt  = 3'd5;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StDivZero = 2'd1;
  localparam logic [1:0] StIterCap = 2'd2;

  localparam logic RegTolerance = 1'b0;
  localparam logic RegMaxIter   = 1'b1;

  localparam logic [15:0] TolReset  = 16'd6;
  localparam logic [7:0]  IterReset = 8'd64;

  // floor(n/3) = (n * Recip3) >> 33 for any 32-bit n
  localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] fx_mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

[rtl/q16_divider.sv]
module q16_divider #(
  parameter int FracBits = q16_pkg::FracBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q16_pkg::div_req_t req_i,
  output q16_pkg::div_rsp_t rsp_o
);
  import q16_pkg::*;

  localparam int NumW  = 32 + FracBits;
  localparam int CntW  = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [31:0]     rem_q, rem_d;
  logic [31:0]     dsr_q, dsr_d;
  logic [31:0]     quot_q, quot_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [32:0]     trial;

  assign trial = {rem_q, num_q[NumW-1]};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = {req_i.dividend, {FracBits{1'b0}}};
      rem_d  = '0;
      dsr_d  = req_i.divisor;
      quot_d = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // one restoring step: shift in the next dividend bit, subtract if it fits
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d  = 32'(trial - {1'b0, dsr_q});
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !req_i.start) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a running division");
  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == '0) else $error("divider count left over");

endmodule

[rtl/q16_fixed_point_math_unit.sv]
// Signed Q16.16 math unit: multiply, divide, float-bits conversion, absolute value and
// Newton square and cube roots, one request at a time. Conversion, abs and unused
// opcodes go straight to the output stage, multiply passes through the registered
// multiplier, and divide waits on the one-bit-a-cycle restoring divider. A root runs
// n Newton iterations of one division each (cube root also uses the shared multiplier
// for the t*t product and the division by three); n is at most max_iterations, or one
// if it is zero. The input is not ready while a request is in progress; a finished
// result waits in an output register while the next request is taken.
module q16_fixed_point_math_unit #(
  parameter int FRAC_BITS = q16_pkg::FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]  status_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import q16_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_MULW   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_RSQ    = 4'd4;
  localparam logic [3:0] S_RSQW   = 4'd5;
  localparam logic [3:0] S_RDIV   = 4'd6;
  localparam logic [3:0] S_RMUL3  = 4'd7;
  localparam logic [3:0] S_RMUL3W = 4'd8;
  localparam logic [3:0] S_RUPD   = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  localparam logic [31:0] TwoFix = 32'(2) << FRAC_BITS;

  logic [3:0]  state_q, state_d;
  logic [15:0] tol_q;
  logic [7:0]  maxit_q;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic        cube_q, cube_d;
  logic [31:0] t_q, t_d;
  logic [8:0]  iter_q, iter_d;
  logic        qneg_q, qneg_d;
  logic        dneg_q, dneg_d;
  logic [31:0] mag_q, mag_d;
  logic [31:0] res_q, res_d;
  logic [1:0]  st_q, st_d;
  logic        ov_q, ov_d;
  logic [31:0] ores_q, ores_d;
  logic [1:0]  ost_q, ost_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic [31:0]        prod_fx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [31:0] quot_s, diff, dmag, dt, tsum;
  logic [8:0]  cap;
  logic [31:0] conv;
  logic [7:0]  f_exp;
  logic [23:0] f_mant;
  logic signed [9:0] f_sh;
  logic [55:0] f_left;
  logic [9:0]  f_rsh;

  q16_divider #(.FracBits(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // float bits to fixed point, exponent field zero-extended into a signed shift amount
  always_comb begin
    f_exp  = operand_a_i[30:23];
    f_mant = {(f_exp != 8'd0), operand_a_i[22:0]};
    f_sh   = 10'($signed({2'b00, f_exp})) - 10'(FloatExpOffset) + 10'(FRAC_BITS);
    f_left = {32'd0, f_mant} << f_sh[4:0];
    f_rsh  = 10'd0 - f_sh;
    if (f_sh < 0) begin
      conv = (f_rsh >= 10'd32) ? 32'd0 : ({8'd0, f_mant} >> f_rsh[4:0]);
    end else begin
      conv = (f_sh >= 10'sd32) ? 32'd0 : f_left[31:0];
    end
    if (operand_a_i[31]) conv = 32'd0 - conv;
  end

  assign prod_fx = prod_q[FRAC_BITS+31:FRAC_BITS];
  assign cap     = (maxit_q == 8'd0) ? 9'd1 : {1'b0, maxit_q};
  assign quot_s  = qneg_q ? (32'd0 - div_rsp.quot) : div_rsp.quot;
  assign diff    = quot_s - t_q;
  assign dmag    = fx_mag(diff);
  assign dt      = dneg_q ? (32'd0 - mag_q) : mag_q;
  assign tsum    = t_q + dt;

  always_comb begin
    state_d = state_q;
    a_d = a_q;  b_d = b_q;  cube_d = cube_q;
    t_d = t_q;  iter_d = iter_q;
    qneg_d = qneg_q;  dneg_d = dneg_q;  mag_d = mag_q;
    res_d = res_q;  st_d = st_q;
    ov_d = ov_q;  ores_d = ores_q;  ost_d = ost_q;
    mul_a = 33'($signed(a_q));
    mul_b = 33'($signed(b_q));
    div_req = '0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          a_d    = operand_a_i;
          b_d    = operand_b_i;
          cube_d = (opcode_i == OpCbrt);
          t_d    = TwoFix;
          iter_d = '0;
          st_d   = StOk;
          res_d  = '0;
          case (opcode_i)
            OpMul: state_d = S_MUL;
            OpDiv: begin
              if (operand_b_i == 32'sd0) begin
                st_d    = StDivZero;
                state_d = S_FIN;
              end else begin
                div_req.start    = 1'b1;
                div_req.dividend = fx_mag(operand_a_i);
                div_req.divisor  = fx_mag(operand_b_i);
                qneg_d  = operand_a_i[31] ^ operand_b_i[31];
                state_d = S_DIV;
              end
            end
            OpFloat: begin
              res_d   = conv;
              state_d = S_FIN;
            end
            OpAbs: begin
              res_d   = fx_mag(operand_a_i);
              state_d = S_FIN;
            end
            OpSqrt, OpCbrt: state_d = S_RSQ;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_MUL: state_d = S_MULW;
      S_MULW: begin
        res_d   = prod_fx;
        state_d = S_FIN;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d   = quot_s;
          state_d = S_FIN;
        end
      end
      S_RSQ: begin
        mul_a = 33'($signed(t_q));
        mul_b = 33'($signed(t_q));
        if (cube_q) begin
          state_d = S_RSQW;
        end else if (t_q == 32'd0) begin
          res_d = t_q;  st_d = StDivZero;  state_d = S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = fx_mag(a_q);
          div_req.divisor  = fx_mag(t_q);
          qneg_d  = a_q[31] ^ t_q[31];
          state_d = S_RDIV;
        end
      end
      S_RSQW: begin
        if (prod_fx == 32'd0) begin
          res_d = t_q;  st_d = StDivZero;  state_d = S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = fx_mag(a_q);
          div_req.divisor  = fx_mag(prod_fx);
          qneg_d  = a_q[31] ^ prod_fx[31];
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_rsp.done) begin
          dneg_d = diff[31];
          if (cube_q) begin
            mag_d   = dmag;
            state_d = S_RMUL3;
          end else begin
            mag_d   = {1'b0, dmag[31:1]};
            state_d = S_RUPD;
          end
        end
      end
      S_RMUL3: begin
        mul_a   = {1'b0, mag_q};
        mul_b   = {1'b0, Recip3};
        state_d = S_RMUL3W;
      end
      S_RMUL3W: begin
        mag_d   = prod_q[64:33];
        state_d = S_RUPD;
      end
      S_RUPD: begin
        t_d    = tsum;
        iter_d = iter_q + 9'd1;
        if (mag_q <= {16'd0, tol_q}) begin
          res_d = tsum;  st_d = StOk;  state_d = S_FIN;
        end else if (iter_q + 9'd1 >= cap) begin
          res_d = tsum;  st_d = StIterCap;  state_d = S_FIN;
        end else begin
          state_d = S_RSQ;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ores_d  = res_q;
          ost_d   = st_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      tol_q   <= TolReset;
      maxit_q <= IterReset;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      iter_q  <= iter_d;
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          RegTolerance: tol_q   <= pwdata[15:0];
          RegMaxIter:   maxit_q <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    cube_q <= cube_d;
    t_q    <= t_d;
    qneg_q <= qneg_d;
    dneg_q <= dneg_d;
    mag_q  <= mag_d;
    res_q  <= res_d;
    st_q   <= st_d;
    ores_q <= ores_d;
    ost_q  <= ost_d;
    prod_q <= mul_a * mul_b;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ov_q;
  assign result_value_o = ores_q;
  assign status_o       = ost_q;
  assign pready         = 1'b1;
  assign prdata         = paddr[2] ? {24'd0, maxit_q} : {16'd0, tol_q};

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV || state_q == S_RDIV))
    else $error("division finished outside a wait state");
  a_iter_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUPD) |-> iter_q < cap) else $error("iteration count beyond cap");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> ost_q != 2'd3) else $error("bad status code");
  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!ov_q || out_ready_i)) |=> (ov_q && ores_q == $past(res_q)))
    else $error("result not loaded");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import q16_pkg::*;

  localparam int          CycleLimit = 6000000;
  localparam logic [2:0]  AddrTol    = {RegTolerance, 2'b00};
  localparam logic [2:0]  AddrIter   = {RegMaxIter, 2'b00};

  typedef struct {
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } math_req_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  status;
  } math_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [1:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  q16_fixed_point_math_unit u_top (.*);

  always #4 clk_i = ~clk_i;

  math_req_t   pending_reqs[$];
  math_res_t   expected_results[$];
  math_req_t   cur_req;
  logic [15:0] tol_q = TolReset;
  logic [7:0]  iter_q = IterReset;
  bit          calm = 1'b0;
  bit          held = 1'b0;
  int          hold_left = 0;
  int          errors = 0;
  int          results_seen = 0;
  int          sent = 0;
  int          cycles = 0;
  int          root_caps = 0;
  int          div_zeros = 0;

  function automatic logic [31:0] q_mul(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    return p[47:16];
  endfunction

  function automatic logic [31:0] q_div(logic [31:0] a, logic [31:0] b, output bit dz);
    logic [63:0] ma, mb, q, r;
    ma = {32'd0, fx_mag(a)};
    mb = {32'd0, fx_mag(b)};
    dz = (mb == 0);
    if (dz) return 32'd0;
    q = ma / mb;
    r = ma % mb;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= mb) begin
        r = r - mb;
        q = q + 1;
      end
    end
    return (a[31] ^ b[31]) ? 32'd0 - q[31:0] : q[31:0];
  endfunction

  function automatic logic [31:0] q_from_float(logic [31:0] bits);
    logic [63:0] mant;
    int          sh;
    logic [31:0] mag;
    mant = {41'd0, bits[22:0]};
    if (bits[30:23] != 0) mant[23] = 1'b1;
    sh = int'(bits[30:23]) - FloatExpOffset + 16;
    if (sh < 0) mag = (-sh >= 32) ? 32'd0 : 32'(mant >> (-sh));
    else        mag = (sh >= 32) ? 32'd0 : 32'(mant << sh);
    return bits[31] ? 32'd0 - mag : mag;
  endfunction

  function automatic math_res_t newton_root(logic [31:0] x, bit cube);
    math_res_t   res;
    logic [31:0] t, q, diff;
    int          cap;
    longint      dt, mag;
    bit          dz;
    t = 32'h0002_0000;
    cap = (iter_q == 0) ? 1 : int'(iter_q);
    for (int i = 0; i < cap; i++) begin
      q = cube ? q_div(x, q_mul(t, t), dz) : q_div(x, t, dz);
      if (dz) begin
        res.value = t;
        res.status = StDivZero;
        return res;
      end
      diff = q - t;
      dt = longint'($signed(diff)) / (cube ? 3 : 2);
      t = t + dt[31:0];
      mag = (dt < 0) ? -dt : dt;
      if (mag <= longint'(tol_q)) begin
        res.value = t;
        res.status = StOk;
        return res;
      end
    end
    res.value = t;
    res.status = StIterCap;
    return res;
  endfunction

  function automatic math_res_t predict_math(math_req_t req);
    math_res_t res;
    bit        dz;
    res.value = '0;
    res.status = StOk;
    case (req.op)
      OpMul:   res.value = q_mul(req.a, req.b);
      OpDiv: begin
        res.value = q_div(req.a, req.b, dz);
        if (dz) res.status = StDivZero;
      end
      OpFloat: res.value = q_from_float(req.a);
      OpAbs:   res.value = fx_mag(req.a);
      OpSqrt:  res = newton_root(req.a, 1'b0);
      OpCbrt:  res = newton_root(req.a, 1'b1);
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0, 1:    v = $urandom();
      2:       v = $urandom_range(0, 32'h00ff_ffff);
      3:       v = $urandom_range(0, 32'h0000_ffff);
      default: v = $urandom_range(0, 3) << 16;
    endcase
    if ($urandom_range(0, 3) == 0) v = 32'd0 - v;
    return v;
  endfunction

  function automatic math_req_t random_req();
    math_req_t req;
    int        r;
    r = $urandom_range(0, 99);
    req.op = (r < 15) ? OpMul : (r < 33) ? OpDiv : (r < 48) ? OpFloat :
             (r < 56) ? OpAbs : (r < 75) ? OpSqrt : (r < 94) ? OpCbrt : 3'($urandom_range(6, 7));
    req.a = random_operand();
    req.b = ($urandom_range(0, 9) == 0) ? 32'd0 : random_operand();
    if (req.op == OpFloat && $urandom_range(0, 2) != 0)
      req.a = {1'($urandom()), 8'($urandom_range(100, 160)), 23'($urandom())};
    if ((req.op == OpSqrt || req.op == OpCbrt) && $urandom_range(0, 3) != 0)
      req.a = $urandom_range(0, 32'h0fff_ffff);
    return req;
  endfunction

  task automatic push_req(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    math_req_t req;
    req.op = op;
    req.a = a;
    req.b = b;
    pending_reqs.push_back(req);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrTol) tol_q = data[15:0];
    else                 iter_q = data[7:0];
  endtask

  task automatic run_phase(int tol, int iter, int count);
    wait_drained();
    apb_write(AddrTol, tol);
    apb_write(AddrIter, iter);
    for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
  endtask

  // driver: hold the request until accepted, then predict its result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_math(cur_req));
        sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= cur_req.op;
          operand_a_i <= cur_req.a;
          operand_b_i <= cur_req.b;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    math_res_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   result_value_o, status_o);
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.status == StIterCap) root_caps++;
          if (exp_res.status == StDivZero) div_zeros++;
          if (result_value_o !== exp_res.value) begin
            errors++;
            $display("%0t: result_value expected %h actual %h", $time,
                     exp_res.value, result_value_o);
          end
          if (status_o !== exp_res.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time,
                     exp_res.status, status_o);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (results_seen >= 700 && !held) begin
        held = 1'b1;
        hold_left = 600;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 18);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners at reset settings
    push_req(OpMul, 32'h7fff_ffff, 32'h7fff_ffff);
    push_req(OpMul, 32'h8000_0000, 32'h8000_0000);
    push_req(OpMul, 32'h8000_0000, 32'hffff_0000);
    push_req(OpDiv, 32'h0003_0000, 32'd0);
    push_req(OpDiv, 32'h8000_0000, 32'hffff_0000);
    push_req(OpDiv, 32'h7fff_ffff, 32'd1);
    push_req(OpDiv, 32'hfffe_0000, 32'h0003_0000);
    push_req(OpFloat, 32'h3f80_0000, 32'd0);
    push_req(OpFloat, 32'h7f80_0000, 32'd0);
    push_req(OpFloat, 32'h7fc0_0001, 32'd0);
    push_req(OpFloat, 32'h0000_0001, 32'd0);
    push_req(OpFloat, 32'h8000_0000, 32'd0);
    push_req(OpFloat, 32'h4f00_0000, 32'd0);
    push_req(OpFloat, 32'hc2f6_0000, 32'd0);
    push_req(OpAbs, 32'h8000_0000, 32'd0);
    push_req(OpAbs, 32'hfffb_0000, 32'd0);
    push_req(OpSqrt, 32'd0, 32'd0);
    push_req(OpSqrt, 32'h0004_0000, 32'd0);
    push_req(OpSqrt, 32'h7fff_ffff, 32'd0);
    push_req(OpSqrt, 32'hffff_0000, 32'd0);
    push_req(OpCbrt, 32'h0008_0000, 32'd0);
    push_req(OpCbrt, 32'd0, 32'd0);
    push_req(OpCbrt, 32'h8000_0000, 32'd0);
    push_req(3'd6, 32'hffff_ffff, 32'hffff_ffff);
    push_req(3'd7, 32'h1234_5678, 32'd0);

    run_phase(0, 255, 12);
    run_phase(65535, 0, 100);
    run_phase(65535, 1, 60);
    run_phase($urandom_range(0, 200), 16, 200);
    calm = 1'b1;
    wait_drained();
    calm = 1'b0;
    // queue random requests at the current settings and wait until the block has emptied
    for (int i = 0; i < 250; i++) pending_reqs.push_back(random_req());
    wait_drained();
    for (int i = 0; i < 200; i++) pending_reqs.push_back(random_req());
    run_phase($urandom_range(0, 65535), $urandom_range(2, 12), 200);
    wait_drained();
    repeat (60) @(posedge clk_i);

    $display("%0d requests through mul, div, conversion, abs and roots over six settings",
             sent);
    $display("%0d results checked, %0d at the iteration cap, %0d divide by zero",
             results_seen, root_caps, div_zeros);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
